// ----- rtl/tisu_pkg.sv -----
// types, constants and interpolation tables of the table interpolating function unit
// no dependencies, imported by every module of the block
`timescale 1ns / 1ps

package tisu_pkg;

  typedef enum logic [1:0] {
    CMD_COS   = 2'd0,
    CMD_SQRT  = 2'd1,
    CMD_RSQRT = 2'd2,
    CMD_ATAN2 = 2'd3
  } cmd_e;

  // log2 of the segment width of each table
  localparam int unsigned SEG_COS   = 9;
  localparam int unsigned SEG_SQRT  = 11;
  localparam int unsigned SEG_RSQRT = 10;
  localparam int unsigned SEG_ASIN  = 10;

  // largest operand of the arcsine table, a sine of 1.0 at a scale of 0x4000 per unit
  localparam logic [15:0] ASIN_MAX = 16'h4000;

  // angle constants, full turn is 65536
  localparam logic [15:0] ANG_QUARTER = 16'h4000;
  localparam logic [15:0] ANG_HALF    = 16'h8000;
  localparam logic [15:0] ANG_3QUART  = 16'hc000;

  // octant code {real negative, imaginary negative, real smaller than imaginary}
  localparam logic [2:0] OCT_PP  = 3'b000;
  localparam logic [2:0] OCT_PPS = 3'b001;
  localparam logic [2:0] OCT_PN  = 3'b010;
  localparam logic [2:0] OCT_PNS = 3'b011;
  localparam logic [2:0] OCT_NP  = 3'b100;
  localparam logic [2:0] OCT_NPS = 3'b101;
  localparam logic [2:0] OCT_NN  = 3'b110;
  localparam logic [2:0] OCT_NNS = 3'b111;

  // decoded operand, after the first stage
  typedef struct packed {
    cmd_e               cmd;
    logic [6:0]         idx;
    logic signed [15:0] off;
    logic [2:0]         oct;
    logic               err;
  } dec_t;

  // table word fetched, after the second stage
  typedef struct packed {
    cmd_e               cmd;
    logic [31:0]        word;
    logic signed [15:0] off;
    logic [2:0]         oct;
    logic               err;
  } lkp_t;

  // packed words: value in the high half, signed slope in the low half
  localparam logic [31:0] TAB_SQRT [33] = '{
    32'h000020c6, 32'h163e0bb6, 32'h1fdf0810, 32'h2720068e, 32'h2d3605ab, 32'h32910511,
    32'h3767049f, 32'h3bd90447, 32'h40000401, 32'h43df03c6, 32'h478b0394, 32'h4b090369,
    32'h4e600344, 32'h51940323, 32'h54a80306, 32'h57a102ec, 32'h5a8102d4, 32'h5d4a02bf,
    32'h5fff02ab, 32'h62a00299, 32'h65300288, 32'h67b00278, 32'h6a21026a, 32'h6c84025c,
    32'h6ed9024f, 32'h71220243, 32'h73600238, 32'h7593022d, 32'h77bb0223, 32'h79da021a,
    32'h7bef0211, 32'h7dfb0208, 32'h7fff0200
  };

  localparam logic [31:0] TAB_RSQRT [33] = '{
    32'h7fff0000, 32'h7fff0000, 32'h7fff0000, 32'h7fff0000, 32'h7c56f8b0, 32'h72b4f47c,
    32'h68a6f742, 32'h60daf912, 32'h5a93fa55, 32'h5562fb41, 32'h50fefbf3, 32'h4d38fc7e,
    32'h49edfcec, 32'h4705fd45, 32'h446ffd8f, 32'h421cfdca, 32'h4000fe01, 32'h3e19fe30,
    32'h3c59fe54, 32'h3abdfe75, 32'h3940fe92, 32'h37dffeac, 32'h3696fec3, 32'h3562fed8,
    32'h3443feea, 32'h3334fefb, 32'h3236ff0a, 32'h3145ff17, 32'h3062ff24, 32'h2f8aff2f,
    32'h2ebeff3a, 32'h2dfbff43, 32'h2d42ff4c
  };

  localparam logic [31:0] TAB_COS [65] = '{
    32'h7ffffffb, 32'h7fd3ffb2, 32'h7f5dff64, 32'h7e98ff15, 32'h7d86fec7, 32'h7c25fe7a,
    32'h7a78fe2e, 32'h7880fde3, 32'h763dfd9a, 32'h73b1fd51, 32'h70defd0b, 32'h6dc6fcc6,
    32'h6a69fc83, 32'h66ccfc43, 32'h62eefc05, 32'h5ed4fbc9, 32'h5a7ffb90, 32'h55f2fb59,
    32'h5131fb26, 32'h4c3dfaf5, 32'h471afac8, 32'h41ccfa9d, 32'h3c54fa77, 32'h36b8fa53,
    32'h30fafa33, 32'h2b1efa17, 32'h2527f9fe, 32'h1f19f9e9, 32'h18f8f9d8, 32'h12c7f9ca,
    32'h0c8bf9c0, 32'h0648f9bb, 32'h0000f9b9, 32'hf9b9f9bb, 32'hf376f9c0, 32'hed3af9ca,
    32'he709f9d8, 32'he0e8f9e9, 32'hdadaf9fe, 32'hd4e3fa17, 32'hcf07fa33, 32'hc949fa53,
    32'hc3adfa77, 32'hbe35fa9d, 32'hb8e7fac8, 32'hb3c4faf5, 32'haed0fb26, 32'haa0ffb59,
    32'ha582fb90, 32'ha12dfbc9, 32'h9d13fc05, 32'h9935fc43, 32'h9598fc83, 32'h923bfcc6,
    32'h8f23fd0b, 32'h8c50fd51, 32'h89c4fd9a, 32'h8781fde3, 32'h8589fe2e, 32'h83dcfe7a,
    32'h827bfec7, 32'h8169ff15, 32'h80a4ff63, 32'h802dffb2, 32'h8000fffa
  };

  localparam logic [31:0] TAB_ASIN [17] = '{
    32'h0000028c, 32'h028c028d, 32'h051c0291, 32'h07b00298, 32'h0a4c02a1, 32'h0cf402ae,
    32'h0fab02bf, 32'h127502d5, 32'h155702f1, 32'h185a0315, 32'h1b850344, 32'h1ee70383,
    32'h229403db, 32'h26af0462, 32'h2b7d054d, 32'h31c30792, 32'h40000f3d
  };

endpackage

// ----- rtl/tisu_decode.sv -----
// first pipeline stage: operand fold, clamp, segment index and offset
// depends on tisu_pkg
`timescale 1ns / 1ps

module tisu_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tisu_pkg::cmd_e       cmd_i,
  input  logic [15:0]          value_a_i,
  input  logic [15:0]          value_b_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tisu_pkg::dec_t       out_o
);
  import tisu_pkg::*;

  function automatic logic [15:0] mag16(input logic [15:0] v);
    // two's complement negate, -32768 gives 0x8000
    return v[15] ? 16'(~v + 16'd1) : v;
  endfunction

  logic        valid_q;
  dec_t        dec_d, dec_q;
  logic [15:0] mag_a, mag_b;
  logic        swap;
  logic [15:0] m_min, m_clip, x_rs;
  logic [16:0] sum;

  always_comb begin
    mag_a  = mag16(value_a_i);
    mag_b  = mag16(value_b_i);
    // equal magnitudes take the imaginary one
    swap   = mag_a < mag_b;
    m_min  = swap ? mag_a : mag_b;
    m_clip = (m_min > ASIN_MAX) ? ASIN_MAX : m_min;
    x_rs   = value_a_i[15] ? 16'd0 : value_a_i;

    dec_d.cmd = cmd_i;
    dec_d.oct = {value_a_i[15], value_b_i[15], swap};
    dec_d.err = 1'b0;
    sum       = '0;
    dec_d.idx = '0;
    dec_d.off = '0;
    unique case (cmd_i)
      CMD_COS: begin
        sum       = {1'b0, mag_a} + (17'd1 << (SEG_COS - 1));
        dec_d.idx = 7'(sum >> SEG_COS);
        dec_d.off = 16'(mag_a << (16 - SEG_COS));
      end
      CMD_SQRT: begin
        sum       = {1'b0, value_a_i} + (17'd1 << (SEG_SQRT - 1));
        dec_d.idx = 7'(sum >> SEG_SQRT);
        dec_d.off = 16'(value_a_i << (16 - SEG_SQRT));
      end
      CMD_RSQRT: begin
        sum       = {1'b0, x_rs} + (17'd1 << (SEG_RSQRT - 1));
        dec_d.idx = 7'(sum >> SEG_RSQRT);
        dec_d.off = 16'(x_rs << (16 - SEG_RSQRT));
        dec_d.err = value_a_i[15];
      end
      CMD_ATAN2: begin
        sum       = {1'b0, m_clip} + (17'd1 << (SEG_ASIN - 1));
        dec_d.idx = 7'(sum >> SEG_ASIN);
        dec_d.off = 16'(m_clip << (16 - SEG_ASIN));
        dec_d.err = m_min > ASIN_MAX;
      end
    endcase
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = dec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      dec_q <= dec_d;
    end
  end

endmodule

// ----- rtl/tisu_lookup.sv -----
// second pipeline stage: table word fetch from the constant tables
// depends on tisu_pkg
`timescale 1ns / 1ps

module tisu_lookup (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tisu_pkg::dec_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tisu_pkg::lkp_t out_o
);
  import tisu_pkg::*;

  logic valid_q;
  lkp_t lkp_d, lkp_q;

  always_comb begin
    lkp_d.cmd  = in_i.cmd;
    lkp_d.off  = in_i.off;
    lkp_d.oct  = in_i.oct;
    lkp_d.err  = in_i.err;
    lkp_d.word = '0;
    unique case (in_i.cmd)
      CMD_COS:   lkp_d.word = TAB_COS[in_i.idx];
      CMD_SQRT:  lkp_d.word = TAB_SQRT[in_i.idx[5:0]];
      CMD_RSQRT: lkp_d.word = TAB_RSQRT[in_i.idx[5:0]];
      CMD_ATAN2: lkp_d.word = TAB_ASIN[in_i.idx[4:0]];
    endcase
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = lkp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      lkp_q <= lkp_d;
    end
  end

endmodule

// ----- rtl/tisu_interp.sv -----
// third and fourth pipeline stages: offset times slope, word add, atan2 unfold
// depends on tisu_pkg; the fourth stage register is the result register
`timescale 1ns / 1ps

module tisu_interp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tisu_pkg::lkp_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [15:0]    result_o,
  output logic           range_error_o
);
  import tisu_pkg::*;

  // multiply stage
  logic               mul_valid_q;
  logic               mul_ready;
  logic signed [15:0] slope;
  logic signed [31:0] prod_d, prod_q;
  lkp_t               mul_q;

  // add stage
  logic               res_valid_q;
  logic [31:0]        sum;
  logic [15:0]        y;
  logic [15:0]        res_d, res_q;
  logic               err_q;

  assign slope  = $signed(in_i.word[15:0]);
  assign prod_d = in_i.off * slope;

  assign mul_ready  = !res_valid_q || out_ready_i;
  assign in_ready_o = !mul_valid_q || mul_ready;

  always_comb begin
    sum   = mul_q.word + unsigned'(prod_q);
    y     = sum[31:16];
    res_d = y;
    if (mul_q.cmd == CMD_ATAN2) begin
      case (mul_q.oct)
        OCT_PP:  res_d = y;
        OCT_PPS: res_d = ANG_QUARTER - y;
        OCT_NPS: res_d = ANG_QUARTER + y;
        OCT_NP:  res_d = ANG_HALF - y;
        OCT_NN:  res_d = ANG_HALF + y;
        OCT_NNS: res_d = ANG_3QUART - y;
        OCT_PNS: res_d = ANG_3QUART + y;
        OCT_PN:  res_d = 16'd0 - y;
        default: res_d = 16'd0 - y;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        mul_valid_q <= in_valid_i;
      end
      if (mul_ready) begin
        res_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mul_q  <= in_i;
      prod_q <= prod_d;
    end
    if (mul_ready && mul_valid_q) begin
      res_q <= res_d;
      err_q <= mul_q.err;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign result_o      = res_q;
  assign range_error_o = err_q;

endmodule

// ----- rtl/table_interp_trig_sqrt_unit.sv -----
// top level of the table interpolating 16-bit function unit
// depends on tisu_pkg, tisu_decode, tisu_lookup and tisu_interp
`timescale 1ns / 1ps

// usage
// - slave stream carries one operation per transaction: tuser selects cosine,
//   square root, reciprocal square root or atan2, tdata carries the operands
// - master stream returns one result per transaction, tuser flags a clamped
//   operand (negative rsqrt input, atan2 smaller magnitude above 0x4000)
// - four register stages: decode, table fetch, multiply, add and unfold
// - a transaction accepted into the decode register passes the table fetch,
//   multiply and add registers in turn before it shows on the master side
// - throughput: one transaction per cycle when not stalled, set by the single
//   table read and the single 16x16 multiplier, each with a stage of its own
// - every stage holds a valid bit; a stage takes new data when it is empty
//   or when the stage after it moves, so bubbles close up under stall
// - when the receiver stalls, the result register holds and the stages fill
//   up behind it; s_axis_tready falls only once all four are full
// - reset clears all valid bits, so no result is shown after reset; no
//   state other than the pipeline exists
module table_interp_trig_sqrt_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value_a [15:0], value_b [31:16]
  input  logic [1:0]  s_axis_tuser,  // cmd [1:0]
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // result [15:0]
  output logic        m_axis_tuser   // range_error [0]
);
  import tisu_pkg::*;

  // stage to stage handshake
  logic dec_valid, dec_ready;
  logic lkp_valid, lkp_ready;
  dec_t dec;
  lkp_t lkp;

  // fold, clamp and segment index
  tisu_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (cmd_e'(s_axis_tuser)),
    .value_a_i   (s_axis_tdata[15:0]),
    .value_b_i   (s_axis_tdata[31:16]),
    .out_valid_o (dec_valid),
    .out_ready_i (dec_ready),
    .out_o       (dec)
  );

  // packed value and slope from the tables
  tisu_lookup u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .in_i        (dec),
    .out_valid_o (lkp_valid),
    .out_ready_i (lkp_ready),
    .out_o       (lkp)
  );

  // offset times slope, then add and unfold into the result register
  tisu_interp u_interp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (lkp_valid),
    .in_ready_o    (lkp_ready),
    .in_i          (lkp),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .result_o      (m_axis_tdata),
    .range_error_o (m_axis_tuser)
  );

endmodule
